[hw/rtl/wpah_pkg.sv]
`timescale 1ns / 1ps

package wpah_pkg;

  // field widths fixed by the external format
  localparam int ADDR_W      = 64;
  localparam int SHIFT_W     = 5;
  localparam int BASE_W      = 44;
  localparam int WLEN_W      = 32;
  localparam int BIN_OUT_W   = 5;
  localparam int CNT_OUT_W   = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 44;

  // default sizing of the histogram
  localparam int BINS_DEF       = 32;
  localparam int COUNT_BITS_DEF = 32;

  // bin numbers travel through the queue at the width of the largest bin count
  localparam int BIN_IDX_W   = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

  // reset values of the configuration registers
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST    = 5'd20;
  localparam logic [BASE_W-1:0]  BASE_PAGE_RST     = '0;
  localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RST = 32'd1000000;

  // one classified access, handed from front to back
  typedef struct packed {
    logic                 in_range;
    logic [BIN_IDX_W-1:0] bin;
    logic                 snap;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hw/rtl/wpah_in_if.sv]
`timescale 1ns / 1ps

interface wpah_in_if;
  logic                          valid;
  logic                          ready;
  logic [wpah_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

[hw/rtl/wpah_out_if.sv]
`timescale 1ns / 1ps

interface wpah_out_if;
  logic                            valid;
  logic                            ready;
  logic [wpah_pkg::BIN_OUT_W-1:0]  bin_index;
  logic [wpah_pkg::CNT_OUT_W-1:0]  hit_count;
  logic [wpah_pkg::CNT_OUT_W-1:0]  dropped_count;
  logic                            last_bin;

  modport source (output valid, output bin_index, output hit_count,
                  output dropped_count, output last_bin, input ready);
  modport sink (input valid, input bin_index, input hit_count,
                input dropped_count, input last_bin, output ready);
endinterface

[hw/rtl/windowed_page_access_histogram_unit.sv]
`timescale 1ns / 1ps

// channel   dir  payload                                        transfer when
// access    in   address[63:0]                                  valid && ready
// result    out  bin_index[4:0] hit_count[31:0]                 valid && ready
//                dropped_count[31:0] last_bin
// cfg       in   cfg_index[1:0] cfg_data[43:0]                  cfg_we
//
// one access a cycle enters the front; the back applies one queued access a cycle
// a window close drains the bin cells one per cycle, one result per bin,
// during which the back takes no access and the 4-entry queue absorbs the front
// reset (synchronous, rst high) zeroes all bins, dropped and window counters at once
// access.ready drops only while the queue is full; result stalls hold the drain

module windowed_page_access_histogram_unit #(
  parameter int BINS       = wpah_pkg::BINS_DEF,
  parameter int COUNT_BITS = wpah_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  wpah_in_if.sink                            access,
  wpah_out_if.source                         result,
  input  logic                               cfg_we,
  input  logic [wpah_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wpah_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [wpah_pkg::SHIFT_W-1:0] page_shift;
  logic [wpah_pkg::BASE_W-1:0]  base_page;
  logic [wpah_pkg::WLEN_W-1:0]  window_length;

  // front to queue
  logic               push;
  wpah_pkg::entry_t   push_entry;
  // queue to back
  logic               q_valid;
  logic               q_pop;
  wpah_pkg::entry_t   q_entry;
  wpah_pkg::q_stat_t  q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift    <= wpah_pkg::PAGE_SHIFT_RST;
      base_page     <= wpah_pkg::BASE_PAGE_RST;
      window_length <= wpah_pkg::WINDOW_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wpah_pkg::REG_PAGE_SHIFT:    page_shift    <= cfg_data[wpah_pkg::SHIFT_W-1:0];
        wpah_pkg::REG_BASE_PAGE:     base_page     <= cfg_data[wpah_pkg::BASE_W-1:0];
        wpah_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[wpah_pkg::WLEN_W-1:0];
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // front: page lookup, range check and window counting
  wpah_front #(.BINS(BINS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .q_full        (q_stat.full),
    .in_valid      (access.valid),
    .address       (access.address),
    .in_ready      (access.ready),
    .page_shift    (page_shift),
    .base_page     (base_page),
    .window_length (window_length),
    .push          (push),
    .push_entry    (push_entry)
  );

  // short queue decoupling the two halves
  wpah_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .stat       (q_stat)
  );

  // back: bin cells, dropped counter and snapshot drain
  wpah_back #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .bin_index     (result.bin_index),
    .hit_count     (result.hit_count),
    .dropped_count (result.dropped_count),
    .last_bin      (result.last_bin)
  );

  // the last result of a snapshot always carries the top bin number
  a_last_bin_index: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_bin) |->
      (result.bin_index == wpah_pkg::BIN_OUT_W'(BINS - 1)))
    else $error("last_bin on a result that is not the top bin");

  // queue occupancy is consistent
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // the queue is never written while it is full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("queue written while full");

endmodule

[hw/rtl/wpah_front.sv]
`timescale 1ns / 1ps

module wpah_front #(
  parameter int BINS = wpah_pkg::BINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_full,
  input  logic                            in_valid,
  input  logic [wpah_pkg::ADDR_W-1:0]     address,
  output logic                            in_ready,
  input  logic [wpah_pkg::SHIFT_W-1:0]    page_shift,
  input  logic [wpah_pkg::BASE_W-1:0]     base_page,
  input  logic [wpah_pkg::WLEN_W-1:0]     window_length,
  output logic                            push,
  output wpah_pkg::entry_t                push_entry
);

  logic [wpah_pkg::WLEN_W-1:0] window_count;
  logic [wpah_pkg::WLEN_W-1:0] window_count_next;
  logic [wpah_pkg::ADDR_W-1:0] page;
  logic                        snap;

  assign in_ready = !q_full;
  // inactive lanes (zero address) are taken and discarded
  assign push = in_valid && in_ready && (address != '0);

  assign page = (address >> page_shift) - wpah_pkg::ADDR_W'(base_page);
  assign window_count_next = window_count + 1'b1;
  assign snap = (window_count_next >= window_length);

  assign push_entry.in_range = (page < wpah_pkg::ADDR_W'(BINS));
  assign push_entry.bin      = page[wpah_pkg::BIN_IDX_W-1:0];
  assign push_entry.snap     = snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
    end else if (push) begin
      window_count <= snap ? '0 : window_count_next;
    end
  end

endmodule

[hw/rtl/wpah_queue.sv]
`timescale 1ns / 1ps

module wpah_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wpah_pkg::entry_t   push_entry,
  input  logic               pop,
  output logic               pop_valid,
  output wpah_pkg::entry_t   pop_entry,
  output wpah_pkg::q_stat_t  stat
);

  wpah_pkg::entry_t               mem [wpah_pkg::QUEUE_DEPTH];
  logic [wpah_pkg::QPTR_W-1:0]    wr_ptr;
  logic [wpah_pkg::QPTR_W-1:0]    rd_ptr;
  logic [wpah_pkg::QPTR_W:0]      count;

  assign stat.full  = (count == (wpah_pkg::QPTR_W + 1)'(wpah_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_valid  = !stat.empty;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/wpah_back.sv]
`timescale 1ns / 1ps

module wpah_back #(
  parameter int BINS       = wpah_pkg::BINS_DEF,
  parameter int COUNT_BITS = wpah_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  wpah_pkg::entry_t                  q_entry,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wpah_pkg::BIN_OUT_W-1:0]    bin_index,
  output logic [wpah_pkg::CNT_OUT_W-1:0]    hit_count,
  output logic [wpah_pkg::CNT_OUT_W-1:0]    dropped_count,
  output logic                              last_bin
);

  localparam int IDX_W = $clog2(BINS);

  typedef enum logic {ST_RUN, ST_DRAIN} state_t;

  state_t                  state;
  logic [COUNT_BITS-1:0]   cnt [BINS];
  logic [COUNT_BITS-1:0]   outside;
  logic [COUNT_BITS-1:0]   outside_next;
  logic [wpah_pkg::CNT_OUT_W-1:0] drop_hold;
  logic [IDX_W-1:0]        idx;
  logic                    load;

  assign q_pop = q_valid && (state == ST_RUN);
  assign load  = (state == ST_DRAIN) && (!out_valid || out_ready);

  always_comb begin
    outside_next = outside;
    if (q_pop && !q_entry.in_range && (outside != '1)) begin
      outside_next = COUNT_BITS'(outside + 1'b1);
    end
  end

  // bin cells: saturating increment on a hit, shift toward bin zero while draining
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BINS; i++) cnt[i] <= '0;
    end else if (load) begin
      for (int i = 0; i < BINS - 1; i++) cnt[i] <= cnt[i + 1];
      cnt[BINS - 1] <= '0;
    end else if (q_pop && q_entry.in_range) begin
      for (int i = 0; i < BINS; i++) begin
        if (q_entry.bin == wpah_pkg::BIN_IDX_W'(i) && cnt[i] != '1) begin
          cnt[i] <= COUNT_BITS'(cnt[i] + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      outside   <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_RUN: begin
          if (q_pop) begin
            if (q_entry.snap) begin
              drop_hold <= (64'(outside_next) > 64'hFFFF_FFFF) ? '1
                                                                : 32'(outside_next);
              outside   <= '0;
              idx       <= '0;
              state     <= ST_DRAIN;
            end else begin
              outside   <= outside_next;
            end
          end
        end
        ST_DRAIN: begin
          if (load) begin
            out_valid     <= 1'b1;
            bin_index     <= wpah_pkg::BIN_OUT_W'(idx);
            hit_count     <= (64'(cnt[0]) > 64'hFFFF_FFFF) ? '1 : 32'(cnt[0]);
            dropped_count <= drop_hold;
            last_bin      <= (idx == IDX_W'(BINS - 1));
            idx           <= IDX_W'(idx + 1'b1);
            if (idx == IDX_W'(BINS - 1)) state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

[test/wpah_histogram_checker.sv]
`timescale 1ns / 1ps

module wpah_histogram_checker import wpah_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  wpah_in_if                    access,
  wpah_out_if                   result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int NBINS = BINS_DEF;

  typedef struct packed {
    logic [BIN_OUT_W-1:0] bin;
    logic [CNT_OUT_W-1:0] hits;
    logic [CNT_OUT_W-1:0] dropped;
    logic                 last;
  } bin_report_t;

  bin_report_t          report_q[$];
  logic [CNT_OUT_W-1:0] bin_hits [NBINS];
  logic [CNT_OUT_W-1:0] dropped_hits;
  logic [WLEN_W-1:0]    window_fill;
  logic [SHIFT_W-1:0]   shift_cfg;
  logic [BASE_W-1:0]    base_cfg;
  logic [WLEN_W-1:0]    wlen_cfg;
  int                   errs = 0;

  // histogram update for one access, queues a full snapshot when the window closes
  task automatic count_access(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] page;
    bin_report_t       rep;
    if (addr == '0) return;
    page = (addr >> shift_cfg) - ADDR_W'(base_cfg);
    if (page < ADDR_W'(NBINS)) begin
      if (bin_hits[int'(page)] != '1) bin_hits[int'(page)] = bin_hits[int'(page)] + 1'b1;
    end else if (dropped_hits != '1) begin
      dropped_hits = dropped_hits + 1'b1;
    end
    window_fill = window_fill + 1'b1;
    if (window_fill < wlen_cfg) return;
    for (int b = 0; b < NBINS; b++) begin
      rep.bin     = BIN_OUT_W'(b);
      rep.hits    = bin_hits[b];
      rep.dropped = dropped_hits;
      rep.last    = (b == NBINS - 1);
      report_q.insert(report_q.size(), rep);
      bin_hits[b] = '0;
    end
    dropped_hits = '0;
    window_fill  = '0;
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    bin_report_t want;
    if (rst) begin
      report_q.delete();
      foreach (bin_hits[b]) bin_hits[b] = '0;
      dropped_hits = '0;
      window_fill  = '0;
      shift_cfg    = PAGE_SHIFT_RST;
      base_cfg     = BASE_PAGE_RST;
      wlen_cfg     = WINDOW_LENGTH_RST;
    end else begin
      if (result.valid && result.ready) begin
        if (report_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, actual bin %0d hits %0d dropped %0d",
                   $time, result.bin_index, result.hit_count, result.dropped_count);
        end else begin
          want = report_q.pop_front();
          check_field("bin_index", 32'(want.bin), 32'(result.bin_index));
          check_field("hit_count", want.hits, result.hit_count);
          check_field("dropped_count", want.dropped, result.dropped_count);
          check_field("last_bin", 32'(want.last), 32'(result.last_bin));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PAGE_SHIFT:    shift_cfg = cfg_data[SHIFT_W-1:0];
          REG_BASE_PAGE:     base_cfg  = cfg_data[BASE_W-1:0];
          REG_WINDOW_LENGTH: wlen_cfg  = cfg_data[WLEN_W-1:0];
          default: ;
        endcase
      end
      if (access.valid && access.ready) count_access(access.address);
    end
    mismatches  <= errs;
    outstanding <= report_q.size();
  end

endmodule

[test/windowed_page_access_histogram_unit_tb.sv]
`timescale 1ns / 1ps

module windowed_page_access_histogram_unit_tb;
  import wpah_pkg::*;

  // longest stretch without any transfer before the run is called hung
  localparam int QUIET_LIMIT   = 5000;
  // idle cycles let pass before a register write, covers queue plus drain
  localparam int SETTLE_CYCLES = 40;
  // long result-side hold that backs the access queue up
  localparam int HOLD_CYCLES   = 300;
  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_kick;
  int                    stall_pct;
  int                    idle_pct;
  int                    mismatches;
  int                    outstanding;
  logic [SHIFT_W-1:0]    cur_shift;
  logic [BASE_W-1:0]     cur_base;

  wpah_in_if  acc_if ();
  wpah_out_if res_if ();

  windowed_page_access_histogram_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .access    (acc_if),
    .result    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // watches both channels and the register port, predicts every snapshot
  wpah_histogram_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .access      (acc_if),
    .result      (res_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, or a counted long hold when kicked
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_kick) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // hang detection: cycles with no transfer on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (acc_if.valid && acc_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("** windowed_page_access_histogram_unit: FAILED **");
    $finish;
  end

  // offer one access, with random idle cycles ahead of it, and wait for its transfer
  task automatic send_access(input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      acc_if.valid <= 1'b0;
      @(posedge clk);
    end
    acc_if.valid   <= 1'b1;
    acc_if.address <= addr;
    do @(posedge clk); while (!acc_if.ready);
  endtask

  // stop offering, wait for every predicted result, then let the queue empty
  task automatic settle();
    acc_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // full register set; words may carry junk above the register width
  task automatic configure(input logic [CFG_DATA_W-1:0] shift_word,
                           input logic [CFG_DATA_W-1:0] base_word,
                           input logic [CFG_DATA_W-1:0] wlen_word);
    write_reg(REG_PAGE_SHIFT, shift_word);
    write_reg(REG_BASE_PAGE, base_word);
    write_reg(REG_WINDOW_LENGTH, wlen_word);
    cfg_we    <= 1'b0;
    cur_shift  = shift_word[SHIFT_W-1:0];
    cur_base   = base_word[BASE_W-1:0];
  endtask

  // mostly pages inside the bin window, some just past it, some below base,
  // some inactive lanes and some fully random addresses
  function automatic logic [ADDR_W-1:0] pick_address(input logic [SHIFT_W-1:0] shift,
                                                     input logic [BASE_W-1:0] base);
    logic [ADDR_W-1:0] page;
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] mask;
    int                roll;
    roll = $urandom_range(99);
    low  = {$urandom, $urandom};
    mask = (64'd1 << shift) - 64'd1;
    if (roll < 8) return '0;
    if (roll >= 82) return low;
    if (roll < 60) page = ADDR_W'(base) + ADDR_W'($urandom_range(31));
    else if (roll < 72) page = ADDR_W'(base) + ADDR_W'($urandom_range(40, 32));
    else page = ADDR_W'(base) - ADDR_W'($urandom_range(4, 1));
    return (page << shift) | (low & mask);
  endfunction

  // one random phase: settle, reprogram, then a run of counted accesses
  task automatic run_phase(input logic [CFG_DATA_W-1:0] shift_word,
                           input logic [CFG_DATA_W-1:0] base_word,
                           input logic [CFG_DATA_W-1:0] wlen_word,
                           input int idle, input int stall, input int items, input bit hold);
    logic [ADDR_W-1:0] addr;
    int                sent;
    sent = 0;
    settle();
    stall_pct <= stall;
    idle_pct   = idle;
    if (hold) hold_kick <= 1'b1;
    configure(shift_word, base_word, wlen_word);
    if (hold) hold_kick <= 1'b0;
    // inactive lanes ride along but do not count toward the phase length
    while (sent < items) begin
      addr = pick_address(cur_shift, cur_base);
      if (addr != '0) sent++;
      send_access(addr);
    end
  endtask

  initial begin : stimulus
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_PAGE_SHIFT;
    cfg_data       <= '0;
    acc_if.valid   <= 1'b0;
    acc_if.address <= '0;
    hold_kick      <= 1'b0;
    stall_pct      <= 0;
    idle_pct        = 0;
    cur_shift       = PAGE_SHIFT_RST;
    cur_base        = BASE_PAGE_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: inactive lane, bin zero, all-ones address goes to dropped
    send_access(64'd0);
    send_access(64'd1);
    send_access('1);
    settle();
    // window length lowered to the running count, next access closes it
    write_reg(REG_WINDOW_LENGTH, 44'd2);
    cfg_we <= 1'b0;
    send_access(64'h0000_0000_0030_0000);
    settle();

    // shift zero, top base page, zero length acts as one; junk above both fields
    configure(44'hFFF_FFFF_FFE0, 44'hFFF_FFFF_FFFF, 44'hFFF_0000_0000);
    send_access(64'h0000_0FFF_FFFF_FFFF);
    send_access(64'h0000_1000_0000_001E);
    send_access(64'h0000_1000_0000_001F);
    send_access(64'h0000_0FFF_FFFF_FFFE);
    send_access(64'd0);
    send_access('1);
    settle();

    // widest shift, base zero, longest window
    configure(44'h000_0000_001F, 44'd0, 44'hFFF_FFFF_FFFF);
    send_access(64'h0000_0000_8000_0000);
    send_access('1);
    settle();
    // write to the unused index must leave every register alone
    write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
    write_reg(REG_WINDOW_LENGTH, 44'd1);
    cfg_we <= 1'b0;
    send_access(64'h0000_0001_0000_0000);

    // random phases: no idling, sender idle, receiver stalls, both
    run_phase(44'd12, 44'd0,           44'd1,  0,  0,  20, 1'b0);
    run_phase(44'd30, 44'd5,           44'd7,  52, 0,  20, 1'b0);
    run_phase(44'd16, 44'h123_4567_89AB, 44'd4, 0,  52, 20, 1'b0);
    run_phase(44'd20, 44'd100,         44'd13, 13, 13, 20, 1'b0);
    // long receiver hold while accesses keep coming, fills the queue
    run_phase(44'd13, 44'hFFF_FFFF_FFFF, 44'd1, 0,  0,  20, 1'b1);
    // window longer than the phase, counts carry into the next one
    run_phase(44'd25, 44'd0,           44'd40, 52, 0,  20, 1'b0);
    run_phase(44'd12, 44'd7,           44'd3,  0,  52, 20, 1'b0);
    run_phase(44'd18, 44'd1000,        44'd9,  13, 13, 20, 1'b0);

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("** windowed_page_access_histogram_unit: PASSED **");
    end else begin
      $display("** windowed_page_access_histogram_unit: FAILED **");
    end
    $finish;
  end

endmodule
